### rtl/fif_pkg.sv
// ----------------------------------------------------------------------------
// Integer field formatter package
// Shared types, codes and character constants for the integer formatter.
// ----------------------------------------------------------------------------
package fif_pkg;

   // Default for the saturation point of the minimum field width.
   localparam int MAX_WIDTH_DEFAULT = 62;

   // Most characters one request may produce.
   localparam int OUT_LIMIT = 64;

   // Field widths of the request and response payloads.
   localparam int OP_W    = 3;
   localparam int LEN_W   = 2;
   localparam int VALUE_W = 64;
   localparam int FW_W    = 6;
   localparam int CHAR_W  = 8;

   // Digit register: 22 four-bit digit slots, enough for 64-bit octal.
   localparam int DIGIT_SLOTS = 22;
   localparam int DIGIT_BITS  = 4 * DIGIT_SLOTS;
   localparam int CNT_W       = 5;

   // Digit counts of the three number bases.
   localparam logic [CNT_W-1:0] DIGITS_DEC = 5'd20;
   localparam logic [CNT_W-1:0] DIGITS_HEX = 5'd16;
   localparam logic [CNT_W-1:0] DIGITS_OCT = 5'd22;

   // Conversion kinds.
   localparam logic [OP_W-1:0] OP_SDEC  = 3'd0;
   localparam logic [OP_W-1:0] OP_UDEC  = 3'd1;
   localparam logic [OP_W-1:0] OP_HEXL  = 3'd2;
   localparam logic [OP_W-1:0] OP_HEXU  = 3'd3;
   localparam logic [OP_W-1:0] OP_OCT   = 3'd4;
   localparam logic [OP_W-1:0] OP_PTR   = 3'd5;

   // Length kinds.
   localparam logic [LEN_W-1:0] LEN_INT = 2'd0;

   // Fixed characters.
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;

   // Digit character tables.
   localparam logic [CHAR_W-1:0] DIGITS_LOWER [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66 };
   localparam logic [CHAR_W-1:0] DIGITS_UPPER [16] = '{
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46 };

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DABBLE,
      ST_SKIP,
      ST_EMIT_ZERO,
      ST_EMIT_X,
      ST_PAD_LEAD,
      ST_SIGN,
      ST_PAD_ZERO,
      ST_DIGITS,
      ST_PAD_TRAIL
   } state_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] digit,
                                                     input logic       upper);
      digit_char = upper ? DIGITS_UPPER[digit] : DIGITS_LOWER[digit];
   endfunction

endpackage

### rtl/fif_if.sv
// ----------------------------------------------------------------------------
// Integer field formatter channels
// Valid/ready channels for format requests and for output characters.
// ----------------------------------------------------------------------------
interface fif_req_if;
   logic                          valid;
   logic                          ready;
   logic [fif_pkg::OP_W-1:0]      operation;
   logic [fif_pkg::LEN_W-1:0]     length_kind;
   logic [fif_pkg::VALUE_W-1:0]   value;
   logic                          left_align;
   logic                          zero_fill;
   logic                          plus_sign;
   logic                          space_sign;
   logic [fif_pkg::FW_W-1:0]      field_width;

   modport source (
      output valid, operation, length_kind, value, left_align, zero_fill,
             plus_sign, space_sign, field_width,
      input  ready
   );
   modport sink (
      input  valid, operation, length_kind, value, left_align, zero_fill,
             plus_sign, space_sign, field_width,
      output ready
   );
endinterface

interface fif_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fif_pkg::CHAR_W-1:0]    character;
   logic                          last_char;

   modport source (
      output valid, character, last_char,
      input  ready
   );
   modport sink (
      input  valid, character, last_char,
      output ready
   );
endinterface

### rtl/format_integer_field.sv
// ----------------------------------------------------------------------------
// Integer field formatter
// Turns one integer conversion request into its ASCII text, one character
// per response transfer, with the final character of the field marked.
// ----------------------------------------------------------------------------
// A request transfer carries the conversion kind, the length kind, the flags,
// the minimum width and the 64-bit argument; the block then sends the text of
// the field as a run of response transfers, one character each, the last one
// flagged with last_char. Requests are taken one at a time: req ready is high
// only while no field is in progress. Hex and octal digits come straight from
// the argument bits; decimal goes through a bit-serial binary-to-BCD
// converter that takes one argument bit per cycle and converts every bit
// before any output. Leading zero digits are then dropped one per cycle (up
// to 19 digits for decimal, 15 for hex, 21 for octal), and after that the
// characters leave at one per cycle as long as the sink keeps taking them.
// Padding and sign phases with nothing to send are passed through without
// output. A request with an unused kind is accepted and produces no
// characters.
// ----------------------------------------------------------------------------
module format_integer_field #(
   parameter int MAX_WIDTH = fif_pkg::MAX_WIDTH_DEFAULT
) (
   input logic     clock,
   input logic     reset,
   fif_req_if.sink   req_chan,
   fif_rsp_if.source rsp_chan
);
   import fif_pkg::*;

   localparam logic [7:0] MAX_W8 = 8'(MAX_WIDTH);
   localparam logic [6:0] LIMIT7 = 7'(OUT_LIMIT);

   // Control and working registers.
   state_type               state_ff, state_in;
   logic [DIGIT_BITS-1:0]   digit_ff, digit_in;
   logic [VALUE_W-1:0]      mag_ff, mag_in;
   logic [5:0]              bitcnt_ff, bitcnt_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    upper_ff, upper_in;
   logic                    ptr_ff, ptr_in;
   logic                    left_ff, left_in;
   logic                    zf_ff, zf_in;
   logic                    has_prefix_ff, has_prefix_in;
   logic [CHAR_W-1:0]       prefix_ff, prefix_in;
   logic [FW_W-1:0]         width_ff, width_in;
   logic [FW_W-1:0]         pad_ff, pad_in;
   logic [6:0]              remain_ff, remain_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;

   // Load-time values.
   logic [VALUE_W-1:0]      narrow_val;
   logic [VALUE_W-1:0]      load_mag;
   logic                    load_neg;
   logic [FW_W-1:0]         width_sat;
   logic [VALUE_W+1:0]      oct_val;
   logic [DIGIT_BITS-1:0]   oct_digits;

   // Double-dabble adjusted digits.
   logic [DIGIT_BITS-1:0]   dabble_adj;

   // Field length figures computed when the digit count is known.
   logic [FW_W-1:0]         body_len;
   logic [FW_W-1:0]         span_len;
   logic [6:0]              out_total;

   logic                    out_free;
   logic                    emit;
   logic [CHAR_W-1:0]       emit_char;
   logic [3:0]              top_digit;

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.character = rsp_char_ff;
   assign rsp_chan.last_char = rsp_last_ff;

   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign top_digit = digit_ff[DIGIT_BITS-1 -: 4];

   // Narrowing, sign handling, width saturation and octal digit split of the incoming request.
   always_comb begin
      if (req_chan.operation == OP_PTR) begin
         narrow_val = req_chan.value;
      end else if (req_chan.length_kind == LEN_INT) begin
         if (req_chan.operation == OP_SDEC) begin
            narrow_val = {{32{req_chan.value[31]}}, req_chan.value[31:0]};
         end else begin
            narrow_val = {32'b0, req_chan.value[31:0]};
         end
      end else begin
         narrow_val = req_chan.value;
      end
      load_neg = (req_chan.operation == OP_SDEC) && narrow_val[VALUE_W-1];
      load_mag = load_neg ? (VALUE_W'(0) - narrow_val) : narrow_val;
      if ({2'b0, req_chan.field_width} > MAX_W8) begin
         width_sat = MAX_W8[FW_W-1:0];
      end else begin
         width_sat = req_chan.field_width;
      end
      oct_val = {2'b0, load_mag};
      for (int j = 0; j < DIGIT_SLOTS; j++) begin
         oct_digits[4*j +: 4] = {1'b0, oct_val[3*j +: 3]};
      end
   end

   // The add-3 part of one shift-and-add-3 step: every BCD digit of five or more gets three.
   always_comb begin
      for (int j = 0; j < DIGIT_SLOTS; j++) begin
         if (digit_ff[4*j +: 4] >= 4'd5) begin
            dabble_adj[4*j +: 4] = digit_ff[4*j +: 4] + 4'd3;
         end else begin
            dabble_adj[4*j +: 4] = digit_ff[4*j +: 4];
         end
      end
   end

   // Length of sign plus digits, the padded span and the capped total.
   always_comb begin
      body_len = FW_W'(cnt_ff) + FW_W'(has_prefix_ff);
      span_len = (width_ff > body_len) ? width_ff : body_len;
      out_total = {1'b0, span_len} + (ptr_ff ? 7'd2 : 7'd0);
      if (out_total > LIMIT7) begin
         out_total = LIMIT7;
      end
   end

   always_comb begin
      state_in      = state_ff;
      digit_in      = digit_ff;
      mag_in        = mag_ff;
      bitcnt_in     = bitcnt_ff;
      cnt_in        = cnt_ff;
      upper_in      = upper_ff;
      ptr_in        = ptr_ff;
      left_in       = left_ff;
      zf_in         = zf_ff;
      has_prefix_in = has_prefix_ff;
      prefix_in     = prefix_ff;
      width_in      = width_ff;
      pad_in        = pad_ff;
      remain_in     = remain_ff;
      emit          = 1'b0;
      emit_char     = CH_SPACE;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid && (req_chan.operation <= OP_PTR)) begin
               mag_in        = load_mag;
               upper_in      = (req_chan.operation == OP_HEXU);
               ptr_in        = (req_chan.operation == OP_PTR);
               left_in       = req_chan.left_align;
               zf_in         = req_chan.zero_fill;
               width_in      = width_sat;
               bitcnt_in     = '1;
               has_prefix_in = 1'b0;
               prefix_in     = CH_SPACE;
               if (req_chan.operation == OP_SDEC) begin
                  if (load_neg) begin
                     has_prefix_in = 1'b1;
                     prefix_in     = CH_MINUS;
                  end else if (req_chan.plus_sign) begin
                     has_prefix_in = 1'b1;
                     prefix_in     = CH_PLUS;
                  end else if (req_chan.space_sign) begin
                     has_prefix_in = 1'b1;
                     prefix_in     = CH_SPACE;
                  end
               end
               case (req_chan.operation)
                  OP_SDEC, OP_UDEC: begin
                     digit_in = '0;
                     cnt_in   = DIGITS_DEC;
                     state_in = ST_DABBLE;
                  end
                  OP_OCT: begin
                     digit_in = oct_digits;
                     cnt_in   = DIGITS_OCT;
                     state_in = ST_SKIP;
                  end
                  default: begin
                     // Hex kinds and pointers: sixteen digits at the top.
                     digit_in = {load_mag, (DIGIT_BITS - VALUE_W)'(0)};
                     cnt_in   = DIGITS_HEX;
                     state_in = ST_SKIP;
                  end
               endcase
            end
         end

         ST_DABBLE: begin
            // The BCD digits sit in the upper twenty slots; the argument's
            // top bit shifts into the lowest of them.
            digit_in = {dabble_adj[DIGIT_BITS-2:8], mag_ff[VALUE_W-1], 8'b0};
            mag_in   = {mag_ff[VALUE_W-2:0], 1'b0};
            bitcnt_in = bitcnt_ff - 6'd1;
            if (bitcnt_ff == '0) begin
               state_in = ST_SKIP;
            end
         end

         ST_SKIP: begin
            if ((cnt_ff != 5'd1) && (top_digit == 4'd0)) begin
               digit_in = {digit_ff[DIGIT_BITS-5:0], 4'b0};
               cnt_in   = cnt_ff - 5'd1;
            end else begin
               pad_in    = (width_ff > body_len) ? (width_ff - body_len) : '0;
               remain_in = out_total;
               state_in  = ptr_ff ? ST_EMIT_ZERO : ST_PAD_LEAD;
            end
         end

         ST_EMIT_ZERO: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = CH_ZERO;
               state_in  = ST_EMIT_X;
            end
         end

         ST_EMIT_X: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = CH_X;
               state_in  = ST_PAD_LEAD;
            end
         end

         ST_PAD_LEAD: begin
            if (!left_ff && !zf_ff && (pad_ff != '0)) begin
               if (out_free) begin
                  emit      = 1'b1;
                  emit_char = CH_SPACE;
                  pad_in    = pad_ff - 6'd1;
               end
            end else begin
               state_in = ST_SIGN;
            end
         end

         ST_SIGN: begin
            if (has_prefix_ff) begin
               if (out_free) begin
                  emit      = 1'b1;
                  emit_char = prefix_ff;
                  state_in  = ST_PAD_ZERO;
               end
            end else begin
               state_in = ST_PAD_ZERO;
            end
         end

         ST_PAD_ZERO: begin
            if (!left_ff && zf_ff && (pad_ff != '0)) begin
               if (out_free) begin
                  emit      = 1'b1;
                  emit_char = CH_ZERO;
                  pad_in    = pad_ff - 6'd1;
               end
            end else begin
               state_in = ST_DIGITS;
            end
         end

         ST_DIGITS: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_char = digit_char(top_digit, upper_ff);
               digit_in  = {digit_ff[DIGIT_BITS-5:0], 4'b0};
               cnt_in    = cnt_ff - 5'd1;
               if (cnt_ff == 5'd1) begin
                  state_in = ST_PAD_TRAIL;
               end
            end
         end

         ST_PAD_TRAIL: begin
            if (left_ff && (pad_ff != '0)) begin
               if (out_free) begin
                  emit      = 1'b1;
                  emit_char = CH_SPACE;
                  pad_in    = pad_ff - 6'd1;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The remaining-character count ends the field, which also cuts off
      // an overlong field at the output limit.
      if (emit) begin
         remain_in = remain_ff - 7'd1;
         if (remain_ff == 7'd1) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_last_in  = (remain_ff == 7'd1);
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff      <= digit_in;
      mag_ff        <= mag_in;
      bitcnt_ff     <= bitcnt_in;
      cnt_ff        <= cnt_in;
      upper_ff      <= upper_in;
      ptr_ff        <= ptr_in;
      left_ff       <= left_in;
      zf_ff         <= zf_in;
      has_prefix_ff <= has_prefix_in;
      prefix_ff     <= prefix_in;
      width_ff      <= width_in;
      pad_ff        <= pad_in;
      remain_ff     <= remain_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule
